FILE: design/rmq_pkg.sv
// shared constants and codes for the rotation matrix to quaternion unit
package rmq_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 14;

  typedef enum logic [1:0] {
    CASE_TRACE = 2'd0,
    CASE_X     = 2'd1,
    CASE_Y     = 2'd2,
    CASE_Z     = 2'd3
  } case_e;

endpackage

FILE: design/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage
module rmq_sqrt #(
  parameter int QW = 16
) (
  input  logic              clk_i,
  input  logic [2*QW-1:0]   rad_i,
  output logic [QW-1:0]     root_o
);

  logic [2*QW-1:0] rad_q  [QW];
  logic [QW+1:0]   rem_q  [QW];
  logic [QW-1:0]   root_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [2*QW-1:0] rad_in;
    logic [QW+1:0]   rem_in;
    logic [QW-1:0]   root_in;
    logic [QW+1:0]   rem_t;
    logic [QW+1:0]   trial;
    logic            ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    assign rem_t = {rem_in[QW-1:0], rad_in[2*QW-1:2*QW-2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[i]  <= rad_in << 2;
      rem_q[i]  <= ge ? (rem_t - trial) : rem_t;
      root_q[i] <= {root_in[QW-2:0], ge};
    end
  end

  assign root_o = root_q[QW-1];

endmodule

FILE: design/rmq_div.sv
// pipelined rounded divide num * 2^frac / (2q) with saturation, one quotient bit per stage
module rmq_div #(
  parameter int DW   = 16,
  parameter int QW   = 16,
  parameter int FRAC = 14
) (
  input  logic                 clk_i,
  input  logic signed [DW:0]   num_i,
  input  logic [QW-1:0]        q_i,
  output logic signed [DW-1:0] res_o
);

  localparam int NW = ((DW + 1 + FRAC) > QW ? (DW + 1 + FRAC) : QW) + 1;

  logic          neg;
  logic [DW:0]   mag;
  logic [NW-1:0] n_full;
  logic [NW-1:0] n_hi;
  logic [QW:0]   den;

  assign neg    = num_i[DW];
  assign mag    = neg ? (DW+1)'(0) - num_i : num_i;
  assign n_full = (NW'(mag) << FRAC) + NW'(q_i);
  assign n_hi   = n_full >> DW;
  assign den    = {q_i, 1'b0};

  logic [DW-1:0] nlow_q;
  logic [QW+1:0] r0_q;
  logic [QW:0]   den0_q;
  logic          ovf0_q;
  logic          neg0_q;

  always_ff @(posedge clk_i) begin
    nlow_q <= n_full[DW-1:0];
    r0_q   <= n_hi[QW+1:0];
    den0_q <= den;
    ovf0_q <= (n_hi >= NW'(den));
    neg0_q <= neg;
  end

  logic [DW-1:0] nb_q   [DW];
  logic [QW+1:0] r_q    [DW];
  logic [QW:0]   den_q  [DW];
  logic [DW-1:0] quot_q [DW];
  logic          ovf_q  [DW];
  logic          neg_q  [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [DW-1:0] nb_in;
    logic [QW+1:0] r_in;
    logic [QW:0]   den_in;
    logic [DW-1:0] quot_in;
    logic          ovf_in;
    logic          neg_in;
    logic [QW+1:0] r_t;
    logic          ge;

    if (i == 0) begin : g_first
      assign nb_in   = nlow_q;
      assign r_in    = r0_q;
      assign den_in  = den0_q;
      assign quot_in = '0;
      assign ovf_in  = ovf0_q;
      assign neg_in  = neg0_q;
    end else begin : g_next
      assign nb_in   = nb_q[i-1];
      assign r_in    = r_q[i-1];
      assign den_in  = den_q[i-1];
      assign quot_in = quot_q[i-1];
      assign ovf_in  = ovf_q[i-1];
      assign neg_in  = neg_q[i-1];
    end

    assign r_t = {r_in[QW:0], nb_in[DW-1]};
    assign ge  = (r_t >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      nb_q[i]   <= nb_in << 1;
      r_q[i]    <= ge ? (r_t - {1'b0, den_in}) : r_t;
      den_q[i]  <= den_in;
      quot_q[i] <= {quot_in[DW-2:0], ge};
      ovf_q[i]  <= ovf_in;
      neg_q[i]  <= neg_in;
    end
  end

  logic [DW-1:0] quot;
  logic          big;
  logic signed [DW-1:0] res_d;
  logic signed [DW-1:0] res_q;

  assign quot = quot_q[DW-1];

  always_comb begin
    big = 1'b0;
    if (neg_q[DW-1]) begin
      big   = ovf_q[DW-1] || (quot[DW-1] && (|quot[DW-2:0]));
      res_d = big ? {1'b1, {(DW-1){1'b0}}} : DW'(0) - quot;
    end else begin
      big   = ovf_q[DW-1] || quot[DW-1];
      res_d = big ? {1'b0, {(DW-1){1'b1}}} : quot;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

FILE: design/rotation_matrix_to_quaternion_unit.sv
// rotation matrix to quaternion converter, top level
// Takes one 3x3 matrix per cycle and returns one quaternion per item. Each item passes a
// front register, the square root pipeline (one root bit per stage) that gives a QW-bit
// root, where QW = (max(DATA_WIDTH, FRAC_BITS + 1) + 2 + FRAC_BITS + 1) / 2, then the
// divide pipeline (one quotient bit per stage) and an output register. busy stays low,
// so an item may be started in every cycle; each result shows for one cycle with done_o high
// and the receiver has to take it then.
module rotation_matrix_to_quaternion_unit #(
  parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] m00_i,
  input  logic signed [DATA_WIDTH-1:0] m01_i,
  input  logic signed [DATA_WIDTH-1:0] m02_i,
  input  logic signed [DATA_WIDTH-1:0] m10_i,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m20_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] quat_w_o,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o,
  output logic [1:0]                   case_taken_o,
  output logic                         bad_input_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int DL  = (DW > FRAC_BITS + 1 ? DW : FRAC_BITS + 1) + 3;
  localparam int RW  = DL - 1 + FRAC_BITS;
  localparam int QW  = (RW + 1) / 2;
  localparam int IW  = 2 * QW;
  localparam int XW  = (QW + 1 > DW) ? QW + 1 : DW;
  localparam int P2  = DW + 2;

  assign busy = 1'b0;

  // front stage: radicands, branch choice, numerators
  logic signed [DL-1:0] a00, a11, a22, one;
  logic signed [DL-1:0] d_tr, d_x, d_y, d_z, d_sel;
  logic signed [DW:0]   a01, a02, a10, a12, a20, a21;
  logic signed [DW:0]   n0, n1, n2;
  rmq_pkg::case_e       sel;

  assign a00 = DL'(m00_i);
  assign a11 = DL'(m11_i);
  assign a22 = DL'(m22_i);
  assign one = DL'(1) <<< FRAC_BITS;
  assign a01 = (DW+1)'(m01_i);
  assign a02 = (DW+1)'(m02_i);
  assign a10 = (DW+1)'(m10_i);
  assign a12 = (DW+1)'(m12_i);
  assign a20 = (DW+1)'(m20_i);
  assign a21 = (DW+1)'(m21_i);

  assign d_tr = one + a00 + a11 + a22;
  assign d_x  = one + a00 - a11 - a22;
  assign d_y  = one + a11 - a00 - a22;
  assign d_z  = one + a22 - a00 - a11;

  always_comb begin
    if (d_tr > 0) begin
      sel = rmq_pkg::CASE_TRACE;
    end else if (a00 > a11 && a00 > a22) begin
      sel = rmq_pkg::CASE_X;
    end else if (a11 > a22) begin
      sel = rmq_pkg::CASE_Y;
    end else begin
      sel = rmq_pkg::CASE_Z;
    end
    unique case (sel)
      rmq_pkg::CASE_TRACE: begin
        d_sel = d_tr;
        n0 = a21 - a12; n1 = a02 - a20; n2 = a10 - a01;
      end
      rmq_pkg::CASE_X: begin
        d_sel = d_x;
        n0 = a21 - a12; n1 = a01 + a10; n2 = a02 + a20;
      end
      rmq_pkg::CASE_Y: begin
        d_sel = d_y;
        n0 = a02 - a20; n1 = a01 + a10; n2 = a12 + a21;
      end
      default: begin
        d_sel = d_z;
        n0 = a10 - a01; n1 = a02 + a20; n2 = a12 + a21;
      end
    endcase
  end

  logic                 v0_q;
  logic [1:0]           sel0_q;
  logic                 bad0_q;
  logic [IW-1:0]        rad0_q;
  logic signed [DW:0]   n00_q, n10_q, n20_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    sel0_q <= sel;
    bad0_q <= !(d_sel > 0);
    rad0_q <= (d_sel > 0) ? (IW'(d_sel[DL-2:0]) << FRAC_BITS) : '0;
    n00_q  <= n0;
    n10_q  <= n1;
    n20_q  <= n2;
  end

  // square root
  logic [QW-1:0] root;

  rmq_sqrt #(.QW(QW)) u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad0_q),
    .root_o (root)
  );

  // payload alongside the square root
  logic               v1_q   [QW];
  logic [1:0]         sel1_q [QW];
  logic               bad1_q [QW];
  logic signed [DW:0] n01_q  [QW];
  logic signed [DW:0] n11_q  [QW];
  logic signed [DW:0] n21_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QW; i++) v1_q[i] <= 1'b0;
    end else begin
      v1_q[0] <= v0_q;
      for (int i = 1; i < QW; i++) v1_q[i] <= v1_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sel1_q[0] <= sel0_q;
    bad1_q[0] <= bad0_q;
    n01_q[0]  <= n00_q;
    n11_q[0]  <= n10_q;
    n21_q[0]  <= n20_q;
    for (int i = 1; i < QW; i++) begin
      sel1_q[i] <= sel1_q[i-1];
      bad1_q[i] <= bad1_q[i-1];
      n01_q[i]  <= n01_q[i-1];
      n11_q[i]  <= n11_q[i-1];
      n21_q[i]  <= n21_q[i-1];
    end
  end

  // dominant component, q/2 rounded half up
  logic [XW-1:0]        dom_w;
  logic signed [DW-1:0] dom;

  assign dom_w = (XW'(root) + XW'(1)) >> 1;
  assign dom   = (dom_w > XW'({1'b0, {(DW-1){1'b1}}})) ? {1'b0, {(DW-1){1'b1}}}
                                                       : dom_w[DW-1:0];

  // three divide lanes
  logic signed [DW-1:0] lane0, lane1, lane2;

  rmq_div #(.DW(DW), .QW(QW), .FRAC(FRAC_BITS)) u_div0 (
    .clk_i (clk_i), .num_i (n01_q[QW-1]), .q_i (root), .res_o (lane0)
  );
  rmq_div #(.DW(DW), .QW(QW), .FRAC(FRAC_BITS)) u_div1 (
    .clk_i (clk_i), .num_i (n11_q[QW-1]), .q_i (root), .res_o (lane1)
  );
  rmq_div #(.DW(DW), .QW(QW), .FRAC(FRAC_BITS)) u_div2 (
    .clk_i (clk_i), .num_i (n21_q[QW-1]), .q_i (root), .res_o (lane2)
  );

  // payload alongside the divide lanes
  logic                 v2_q   [P2];
  logic [1:0]           sel2_q [P2];
  logic                 bad2_q [P2];
  logic signed [DW-1:0] dom2_q [P2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < P2; i++) v2_q[i] <= 1'b0;
    end else begin
      v2_q[0] <= v1_q[QW-1];
      for (int i = 1; i < P2; i++) v2_q[i] <= v2_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sel2_q[0] <= sel1_q[QW-1];
    bad2_q[0] <= bad1_q[QW-1];
    dom2_q[0] <= dom;
    for (int i = 1; i < P2; i++) begin
      sel2_q[i] <= sel2_q[i-1];
      bad2_q[i] <= bad2_q[i-1];
      dom2_q[i] <= dom2_q[i-1];
    end
  end

  // place components and register the result
  logic signed [DW-1:0] w_d, x_d, y_d, z_d, dm;
  logic                 bad_f;

  assign dm    = dom2_q[P2-1];
  assign bad_f = bad2_q[P2-1];

  always_comb begin
    unique case (rmq_pkg::case_e'(sel2_q[P2-1]))
      rmq_pkg::CASE_TRACE: begin
        w_d = dm;    x_d = lane0; y_d = lane1; z_d = lane2;
      end
      rmq_pkg::CASE_X: begin
        w_d = lane0; x_d = dm;    y_d = lane1; z_d = lane2;
      end
      rmq_pkg::CASE_Y: begin
        w_d = lane0; x_d = lane1; y_d = dm;    z_d = lane2;
      end
      default: begin
        w_d = lane0; x_d = lane1; y_d = lane2; z_d = dm;
      end
    endcase
  end

  logic                 done_q;
  logic signed [DW-1:0] w_q, x_q, y_q, z_q;
  logic [1:0]           case_q;
  logic                 bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v2_q[P2-1];
    end
  end

  always_ff @(posedge clk_i) begin
    w_q    <= bad_f ? '0 : w_d;
    x_q    <= bad_f ? '0 : x_d;
    y_q    <= bad_f ? '0 : y_d;
    z_q    <= bad_f ? '0 : z_d;
    case_q <= sel2_q[P2-1];
    bad_q  <= bad_f;
  end

  assign done_o       = done_q;
  assign quat_w_o     = w_q;
  assign quat_x_o     = x_q;
  assign quat_y_o     = y_q;
  assign quat_z_o     = z_q;
  assign case_taken_o = case_q;
  assign bad_input_o  = bad_q;

endmodule

FILE: verif/rotation_matrix_to_quaternion_unit_test.sv
// testbench for the rotation matrix to quaternion unit: directed table then random matrices
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_unit_test;

  localparam int DW = rmq_pkg::DATA_WIDTH_DEF;
  localparam int FB = rmq_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam longint SMAX = (longint'(1) << (DW - 1)) - 1;
  localparam longint SMIN = -(longint'(1) << (DW - 1));
  localparam int LATENCY = 36;
  localparam int N_RANDOM = 1750;

  typedef logic signed [DW-1:0] elem_t;

  typedef struct packed {
    elem_t w;
    elem_t x;
    elem_t y;
    elem_t z;
    rmq_pkg::case_e sel;
    logic  bad;
  } quat_t;

  typedef struct {
    elem_t m [9];
    logic  has_exp;
    quat_t exp_q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  elem_t m_i [9];
  logic done_o;
  elem_t quat_w_o, quat_x_o, quat_y_o, quat_z_o;
  logic [1:0] case_taken_o;
  logic bad_input_o;

  quat_t pending_quats [$];
  int errors = 0;
  row_t rows [$];

  initial for (int i = 0; i < 9; i++) m_i[i] = '0;

  rotation_matrix_to_quaternion_unit uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .m00_i(m_i[0]), .m01_i(m_i[1]), .m02_i(m_i[2]),
    .m10_i(m_i[3]), .m11_i(m_i[4]), .m12_i(m_i[5]),
    .m20_i(m_i[6]), .m21_i(m_i[7]), .m22_i(m_i[8]),
    .done_o(done_o), .quat_w_o(quat_w_o), .quat_x_o(quat_x_o),
    .quat_y_o(quat_y_o), .quat_z_o(quat_z_o),
    .case_taken_o(case_taken_o), .bad_input_o(bad_input_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint sat_q(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint root_q(longint n);
    longint lo, hi, mid;
    lo = 0;
    hi = 1 << 20;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= n) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic longint div_round(longint num, longint q);
    longint mag, r;
    mag = num < 0 ? -num : num;
    r = ((mag << FB) + q) / (2 * q);
    return sat_q(num < 0 ? -r : r);
  endfunction

  function automatic quat_t convert_matrix(elem_t m [9]);
    longint a [9];
    longint num [3];
    longint comp [4];
    longint d, q;
    quat_t r;
    int j;
    for (int i = 0; i < 9; i++) a[i] = longint'(m[i]);
    comp = '{0, 0, 0, 0};
    r.bad = 1'b0;
    d = ONE_Q + a[0] + a[4] + a[8];
    if (d > 0) begin
      r.sel = rmq_pkg::CASE_TRACE;
      num = '{a[7] - a[5], a[2] - a[6], a[3] - a[1]};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      r.sel = rmq_pkg::CASE_X;
      d = ONE_Q + a[0] - a[4] - a[8];
      num = '{a[7] - a[5], a[1] + a[3], a[2] + a[6]};
    end else if (a[4] > a[8]) begin
      r.sel = rmq_pkg::CASE_Y;
      d = ONE_Q + a[4] - a[0] - a[8];
      num = '{a[2] - a[6], a[1] + a[3], a[5] + a[7]};
    end else begin
      r.sel = rmq_pkg::CASE_Z;
      d = ONE_Q + a[8] - a[0] - a[4];
      num = '{a[3] - a[1], a[2] + a[6], a[5] + a[7]};
    end
    if (d <= 0) begin
      r.bad = 1'b1;
    end else begin
      q = root_q(d << FB);
      comp[r.sel] = sat_q((q + 1) >> 1);
      j = 0;
      for (int k = 0; k < 4; k++) begin
        if (k != int'(r.sel)) begin
          comp[k] = div_round(num[j], q);
          j++;
        end
      end
    end
    r.w = elem_t'(comp[0]);
    r.x = elem_t'(comp[1]);
    r.y = elem_t'(comp[2]);
    r.z = elem_t'(comp[3]);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && done_o) begin
      if (pending_quats.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = pending_quats.pop_front();
        if (quat_w_o !== e.w) report_mismatch("quat_w", quat_w_o, e.w);
        if (quat_x_o !== e.x) report_mismatch("quat_x", quat_x_o, e.x);
        if (quat_y_o !== e.y) report_mismatch("quat_y", quat_y_o, e.y);
        if (quat_z_o !== e.z) report_mismatch("quat_z", quat_z_o, e.z);
        if (case_taken_o !== e.sel) report_mismatch("case_taken", case_taken_o, e.sel);
        if (bad_input_o !== e.bad) report_mismatch("bad_input", bad_input_o, e.bad);
      end
    end
  end

  function automatic row_t make_row(int v0, int v1, int v2, int v3, int v4, int v5,
                                    int v6, int v7, int v8);
    row_t r;
    r.m = '{elem_t'(v0), elem_t'(v1), elem_t'(v2), elem_t'(v3), elem_t'(v4),
            elem_t'(v5), elem_t'(v6), elem_t'(v7), elem_t'(v8)};
    r.has_exp = 1'b0;
    r.exp_q = '0;
    return r;
  endfunction

  function automatic row_t known_row(row_t r, int w, int x, int y, int z,
                                     rmq_pkg::case_e s, logic b);
    r.has_exp = 1'b1;
    r.exp_q = '{elem_t'(w), elem_t'(x), elem_t'(y), elem_t'(z), s, b};
    return r;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32768) - 16384);
      default: return elem_t'($urandom_range(0, 8) * 8192 - 32768 + $urandom_range(0, 3));
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    int mode;
    mode = $urandom_range(0, 2);
    for (int i = 0; i < 9; i++) r.m[i] = rand_elem(mode);
    if ($urandom_range(0, 3) == 0) begin
      r.m[$urandom_range(0, 2) * 4] = elem_t'(16384);
      r.m[0] = elem_t'(-16384 - $urandom_range(0, 100));
    end
    r.has_exp = 1'b0;
    r.exp_q = '0;
    return r;
  endfunction

  task automatic send_row(row_t r, bit idle_on);
    while (idle_on && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    for (int i = 0; i < 9; i++) m_i[i] <= r.m[i];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_quats.push_back(r.has_exp ? r.exp_q : convert_matrix(r.m));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_quats.size() != 0);
  endtask

  initial begin
    rows.push_back(known_row(make_row(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                             16384, 0, 0, 0, rmq_pkg::CASE_TRACE, 1'b0));
    rows.push_back(known_row(make_row(0, 0, 0, 0, 0, 0, 0, 0, 0),
                             8192, 0, 0, 0, rmq_pkg::CASE_TRACE, 1'b0));
    rows.push_back(known_row(make_row(16384, 0, 0, 0, -16384, 0, 0, 0, -16384),
                             0, 16384, 0, 0, rmq_pkg::CASE_X, 1'b0));
    rows.push_back(known_row(make_row(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384),
                             0, 0, 16384, 0, rmq_pkg::CASE_Y, 1'b0));
    rows.push_back(known_row(make_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384),
                             0, 0, 0, 16384, rmq_pkg::CASE_Z, 1'b0));
    rows.push_back(make_row(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    rows.push_back(make_row(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    rows.push_back(make_row(-16384, 5, 5, 5, -16384, 5, 5, 5, -16384));
    rows.push_back(make_row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    rows.push_back(make_row(-16383, 32767, -32768, -32768, -16384, 32767, 32767, -32768,
                            -16384));
    rows.push_back(make_row(32767, -32768, 32767, 32767, -32768, -32768, -32768, 32767,
                            -32768));
    rows.push_back(make_row(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                            -32768));
    rows.push_back(make_row(-20000, 100, -100, 100, -20000, 100, -100, 100, -20000));
    rows.push_back(make_row(-16384, 7, 9, -7, 0, 3, 9, 3, -16384));
    rows.push_back(make_row(-16384, 0, 0, 0, -16384, 0, 0, 0, 0));
    rows.push_back(make_row(-16385, 32767, 32767, 32767, -16385, 32767, 32767, 32767,
                            -16384));
    rows.push_back(make_row(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384));
    rows.push_back(make_row(-20000, 1, 2, 3, -20000, 4, 5, 6, -20001));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_row(rows[i], 1'b0);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) drain();
      send_row(rand_row(), !(n >= 900 && n < 1200));
    end

    drain();
    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
